// File: rtl/stc_pkg.sv
// Shared types, constants and tables for the seconds / calendar converter.
// No dependencies; used by stc_to_fields, stc_to_seconds and the top level.
package stc_pkg;

  // Field widths
  localparam int SEC_W   = 39;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;

  // Pipeline depth, identical for both directions
  localparam int LATENCY = 13;

  localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

  // Period lengths in days
  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [10:0] DAYS_4Y   = 11'd1461;
  localparam logic [8:0]  DAYS_1Y   = 9'd365;

  // 86400 = 675 << 7; days = (s >> 7) / 675
  localparam logic [9:0]  DAY_ODD    = 10'd675;
  // floor(2^32 / 675): quotient low by at most one
  localparam logic [22:0] DAY_RECIP  = 23'd6362914;
  // ceil(2^29 / 3600) and ceil(2^23 / 60): exact for values below 86400
  localparam logic [17:0] HOUR_RECIP = 18'd149131;
  localparam logic [17:0] MIN_RECIP  = 18'd139811;
  // floor(2^23 / 146097) and floor(2^16 / 1461): low by at most one
  localparam logic [5:0]  Q400_RECIP = 6'd57;
  localparam logic [5:0]  Q4_RECIP   = 6'd44;
  // ceil(2^21 / 100): exact for 14-bit values
  localparam logic [14:0] DIV100_RECIP = 15'd20972;

  typedef struct packed {
    logic                 valid_res;
    logic [SEC_W-1:0]     seconds;
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hour;
    logic [MIN_W-1:0]     minute;
    logic [MIN_W-1:0]     second;
  } res_t;

  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hour;
    logic [MIN_W-1:0]     minute;
    logic [MIN_W-1:0]     second;
  } cal_t;

  // Days before the first of month idx+1 (idx 0..12); 0 for meaningless codes
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      4'd12:   v = 9'd365;
      default: v = 9'd0;
    endcase
    if (leap && idx >= 4'd2 && idx <= 4'd12) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

endpackage

// File: rtl/seconds_to_calendar_convert.sv
// Top level of the seconds / proleptic Gregorian calendar converter.
// Depends on stc_pkg, stc_to_fields and stc_to_seconds.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ------------------------------------
//   request   in_action, in_total_seconds,   taken at a clock edge with start high
//             in_year_in .. in_second_in     and busy low
//   result    out_valid_res .. out_second_out  out_strobe high for one cycle
//
// A request is taken every cycle (busy stays low); its result passes through
//   LATENCY pipeline stages. The depth is set by the seconds-to-fields
//   chain: day split, 400/100/4/1-year reductions, then month and day.
// The fields-to-seconds direction runs its own 6 stages and a delay line so
//   results leave in request order with no collision.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// The receiver cannot stall, so the pipeline advances every cycle.
module seconds_to_calendar_convert (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [stc_pkg::SEC_W-1:0]   in_total_seconds,
  input  logic [stc_pkg::YEAR_W-1:0]  in_year_in,
  input  logic [stc_pkg::MONTH_W-1:0] in_month_in,
  input  logic [stc_pkg::DAY_W-1:0]   in_day_in,
  input  logic [stc_pkg::HOUR_W-1:0]  in_hour_in,
  input  logic [stc_pkg::MIN_W-1:0]   in_minute_in,
  input  logic [stc_pkg::MIN_W-1:0]   in_second_in,
  output logic                        out_strobe,
  output logic                        out_valid_res,
  output logic [stc_pkg::SEC_W-1:0]   out_seconds_out,
  output logic [stc_pkg::YEAR_W-1:0]  out_year_out,
  output logic [stc_pkg::MONTH_W-1:0] out_month_out,
  output logic [stc_pkg::DAY_W-1:0]   out_day_out,
  output logic [stc_pkg::HOUR_W-1:0]  out_hour_out,
  output logic [stc_pkg::MIN_W-1:0]   out_minute_out,
  output logic [stc_pkg::MIN_W-1:0]   out_second_out
);
  import stc_pkg::*;

  logic  req_take;
  logic  f_vld, s_vld;
  res_t  f_res, s_res, res;
  cal_t  cal_in;

  // Fully pipelined: never refuses a request
  assign busy     = 1'b0;
  assign req_take = start && !busy;

  assign cal_in.year   = in_year_in;
  assign cal_in.month  = in_month_in;
  assign cal_in.day    = in_day_in;
  assign cal_in.hour   = in_hour_in;
  assign cal_in.minute = in_minute_in;
  assign cal_in.second = in_second_in;

  // Direction picks which pipeline the request enters
  stc_to_fields u_fields (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (req_take && !in_action),
    .in_seconds (in_total_seconds),
    .out_vld    (f_vld),
    .out_res    (f_res)
  );

  stc_to_seconds u_seconds (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (req_take && in_action),
    .in_cal  (cal_in),
    .out_vld (s_vld),
    .out_res (s_res)
  );

  // Equal depths: at most one of the two strobes is high in a cycle
  assign res        = f_vld ? f_res : s_res;
  assign out_strobe = f_vld || s_vld;

  assign out_valid_res   = res.valid_res;
  assign out_seconds_out = res.seconds;
  assign out_year_out    = res.year;
  assign out_month_out   = res.month;
  assign out_day_out     = res.day;
  assign out_hour_out    = res.hour;
  assign out_minute_out  = res.minute;
  assign out_second_out  = res.second;

endmodule

// File: rtl/stc_to_fields.sv
// Seconds-to-calendar pipeline, LATENCY stages, one request per cycle.
// Depends on stc_pkg (widths, period constants, reciprocals, month table).
module stc_to_fields (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [stc_pkg::SEC_W-1:0] in_seconds,
  output logic                      out_vld,
  output stc_pkg::res_t             out_res
);
  import stc_pkg::*;

  localparam int NST = LATENCY - 1;

  typedef struct packed {
    logic [31:0] x;
    logic [6:0]  s_lo;
    logic [22:0] dq;
    logic [10:0] dr;
    logic [16:0] rem;
    logic [4:0]  hour;
    logic [10:0] mday;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [5:0]  q400;
    logic [18:0] d400r;
    logic [17:0] d400;
    logic [1:0]  q100;
    logic [15:0] d100;
    logic [4:0]  q4;
    logic [11:0] d4r;
    logic [10:0] d4;
    logic [1:0]  q1;
    logic [8:0]  doy;
    logic [14:0] year;
    logic        leap;
    logic [3:0]  month;
    logic        ok;
  } tf_t;

  logic [LATENCY:1] vld_r;
  tf_t              st_r   [1:NST];
  tf_t              st_nxt [1:NST];
  res_t             res_r, res_nxt;

  logic [54:0] p1;
  logic [31:0] m2;
  logic [34:0] hp4, mp4;
  logic [28:0] qp4;
  logic [21:0] qp8;
  logic [3:0]  mcnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-1:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NST; k++) begin
      st_r[k] <= st_nxt[k];
    end
    res_r <= res_nxt;
  end

  // 1: approximate day quotient
  assign p1 = 55'(in_seconds[38:7]) * 55'(DAY_RECIP);
  always_comb begin
    st_nxt[1]      = '0;
    st_nxt[1].x    = in_seconds[38:7];
    st_nxt[1].s_lo = in_seconds[6:0];
    st_nxt[1].dq   = p1[54:32];
  end

  // 2: remainder of the approximation
  assign m2 = 32'(st_r[1].dq) * 32'(DAY_ODD);
  always_comb begin
    st_nxt[2]    = st_r[1];
    st_nxt[2].dr = 11'(st_r[1].x - m2);
  end

  // 3: correct by one, rebuild second of day
  always_comb begin
    st_nxt[3] = st_r[2];
    if (st_r[2].dr >= 11'(DAY_ODD)) begin
      st_nxt[3].dq  = st_r[2].dq + 23'd1;
      st_nxt[3].rem = {10'(st_r[2].dr - 11'(DAY_ODD)), st_r[2].s_lo};
    end else begin
      st_nxt[3].rem = {st_r[2].dr[9:0], st_r[2].s_lo};
    end
  end

  // 4: hour, minute of day, approximate 400-year count
  assign hp4 = 35'(st_r[3].rem) * 35'(HOUR_RECIP);
  assign mp4 = 35'(st_r[3].rem) * 35'(MIN_RECIP);
  assign qp4 = 29'(st_r[3].dq) * 29'(Q400_RECIP);
  always_comb begin
    st_nxt[4]      = st_r[3];
    st_nxt[4].hour = hp4[33:29];
    st_nxt[4].mday = mp4[33:23];
    st_nxt[4].q400 = qp4[28:23];
  end

  // 5: minute, second, 400-year remainder
  always_comb begin
    st_nxt[5]        = st_r[4];
    st_nxt[5].second = 6'(st_r[4].rem - 17'(st_r[4].mday) * 17'd60);
    st_nxt[5].minute = 6'(st_r[4].mday - 11'(st_r[4].hour) * 11'd60);
    st_nxt[5].d400r  = 19'(st_r[4].dq - 23'(st_r[4].q400) * 23'(DAYS_400Y));
  end

  // 6: correct 400-year count
  always_comb begin
    st_nxt[6] = st_r[5];
    if (st_r[5].d400r >= 19'(DAYS_400Y)) begin
      st_nxt[6].q400 = st_r[5].q400 + 6'd1;
      st_nxt[6].d400 = 18'(st_r[5].d400r - 19'(DAYS_400Y));
    end else begin
      st_nxt[6].d400 = st_r[5].d400r[17:0];
    end
  end

  // 7: century count by compare, capped at 3
  always_comb begin
    st_nxt[7]      = st_r[6];
    st_nxt[7].q100 = 2'(st_r[6].d400 >= 18'(DAYS_100Y))
                   + 2'(st_r[6].d400 >= 18'(2 * DAYS_100Y))
                   + 2'(st_r[6].d400 >= 18'(3 * DAYS_100Y));
    st_nxt[7].d100 = 16'(st_r[6].d400 - 18'(st_nxt[7].q100) * 18'(DAYS_100Y));
    st_nxt[7].year = 15'(st_r[6].q400) * 15'd400 + 15'(st_nxt[7].q100) * 15'd100 + 15'd1;
  end

  // 8: approximate 4-year count
  assign qp8 = 22'(st_r[7].d100) * 22'(Q4_RECIP);
  always_comb begin
    st_nxt[8]    = st_r[7];
    st_nxt[8].q4 = qp8[20:16];
  end

  // 9: 4-year remainder
  always_comb begin
    st_nxt[9]     = st_r[8];
    st_nxt[9].d4r = 12'(st_r[8].d100 - 16'(st_r[8].q4) * 16'(DAYS_4Y));
  end

  // 10: correct 4-year count; century remainder stays below 25 periods,
  // so the count never exceeds 24
  always_comb begin
    st_nxt[10] = st_r[9];
    if (st_r[9].d4r >= 12'(DAYS_4Y)) begin
      st_nxt[10].q4 = st_r[9].q4 + 5'd1;
      st_nxt[10].d4 = 11'(st_r[9].d4r - 12'(DAYS_4Y));
    end else begin
      st_nxt[10].d4 = st_r[9].d4r[10:0];
    end
  end

  // 11: year within the 4-year period, capped at 3; leap flag
  always_comb begin
    st_nxt[11]      = st_r[10];
    st_nxt[11].q1   = 2'(st_r[10].d4 >= 11'(DAYS_1Y))
                    + 2'(st_r[10].d4 >= 11'(2 * DAYS_1Y))
                    + 2'(st_r[10].d4 >= 11'(3 * DAYS_1Y));
    st_nxt[11].doy  = 9'(st_r[10].d4 - 11'(st_nxt[11].q1) * 11'(DAYS_1Y));
    st_nxt[11].year = st_r[10].year + 15'({st_r[10].q4, 2'b00}) + 15'(st_nxt[11].q1);
    st_nxt[11].leap = (st_nxt[11].q1 == 2'd3) &&
                      ((st_r[10].q4 != 5'd24) || (st_r[10].q100 == 2'd3));
  end

  // 12: month by parallel compare, range check
  always_comb begin
    mcnt = 4'd1;
    for (int k = 1; k < 12; k++) begin
      mcnt = mcnt + 4'(st_r[11].doy >= cum_days(st_r[11].leap, 4'(k)));
    end
  end
  always_comb begin
    st_nxt[12]       = st_r[11];
    st_nxt[12].month = mcnt;
    st_nxt[12].ok    = st_r[11].year <= 15'(MAX_YEAR);
  end

  // 13: day of month, result register
  always_comb begin
    res_nxt = '0;
    if (st_r[12].ok) begin
      res_nxt.valid_res = 1'b1;
      res_nxt.year      = st_r[12].year[13:0];
      res_nxt.month     = st_r[12].month;
      res_nxt.day       = 5'(st_r[12].doy
                        - cum_days(st_r[12].leap, st_r[12].month - 4'd1) + 9'd1);
      res_nxt.hour      = st_r[12].hour;
      res_nxt.minute    = st_r[12].minute;
      res_nxt.second    = st_r[12].second;
    end
  end

  assign out_vld = vld_r[LATENCY];
  assign out_res = res_r;

endmodule

// File: rtl/stc_to_seconds.sv
// Calendar-to-seconds pipeline: validation, day count, seconds, then a delay
// line so it lines up with stc_to_fields. Depends on stc_pkg.
module stc_to_seconds (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  stc_pkg::cal_t in_cal,
  output logic          out_vld,
  output stc_pkg::res_t out_res
);
  import stc_pkg::*;

  localparam int TS_ST = 6;

  typedef struct packed {
    cal_t        c;
    logic [13:0] p;
    logic [7:0]  yq;
    logic [7:0]  pq;
    logic        leap;
    logic        ok;
    logic [22:0] base;
    logic [22:0] days;
    logic [27:0] hrs;
    logic [33:0] mins;
  } ts_t;

  logic [LATENCY:1] vld_r;
  ts_t              st_r   [1:TS_ST-1];
  ts_t              st_nxt [1:TS_ST-1];
  res_t             res_nxt;
  res_t             dly_r  [TS_ST:LATENCY];

  logic [28:0] yp1, pp1;
  logic [6:0]  ymod;
  logic [8:0]  mlen;
  logic [39:0] secs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-1:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k < TS_ST; k++) begin
      st_r[k] <= st_nxt[k];
    end
    dly_r[TS_ST] <= res_nxt;
    for (int k = TS_ST + 1; k <= LATENCY; k++) begin
      dly_r[k] <= dly_r[k-1];
    end
  end

  // 1: y/100 and (y-1)/100
  assign yp1 = 29'(in_cal.year) * 29'(DIV100_RECIP);
  assign pp1 = 29'(in_cal.year - 14'd1) * 29'(DIV100_RECIP);
  always_comb begin
    st_nxt[1]    = '0;
    st_nxt[1].c  = in_cal;
    st_nxt[1].p  = in_cal.year - 14'd1;
    st_nxt[1].yq = yp1[28:21];
    st_nxt[1].pq = pp1[28:21];
  end

  // 2: leap flag, field checks, days before the year
  assign ymod = 7'(st_r[1].c.year - 14'(st_r[1].yq) * 14'd100);
  always_comb begin
    st_nxt[2]      = st_r[1];
    st_nxt[2].leap = (st_r[1].c.year[1:0] == 2'b00) &&
                     ((ymod != 7'd0) || (st_r[1].yq[1:0] == 2'b00));
    st_nxt[2].base = 23'(st_r[1].p) * 23'(DAYS_1Y) + 23'(st_r[1].p[13:2])
                   - 23'(st_r[1].pq) + 23'(st_r[1].pq[7:2]);
    st_nxt[2].ok   = (st_r[1].c.year != '0) && (st_r[1].c.year <= MAX_YEAR) &&
                     (st_r[1].c.month != '0) && (st_r[1].c.month <= 4'd12) &&
                     (st_r[1].c.hour <= 5'd23) && (st_r[1].c.minute <= 6'd59) &&
                     (st_r[1].c.second <= 6'd59);
  end

  // 3: day-of-month check, day count
  assign mlen = cum_days(st_r[2].leap, st_r[2].c.month)
              - cum_days(st_r[2].leap, st_r[2].c.month - 4'd1);
  always_comb begin
    st_nxt[3]      = st_r[2];
    st_nxt[3].ok   = st_r[2].ok && (st_r[2].c.day != '0) && (9'(st_r[2].c.day) <= mlen);
    st_nxt[3].days = st_r[2].base
                   + 23'(cum_days(st_r[2].leap, st_r[2].c.month - 4'd1))
                   + 23'(st_r[2].c.day) - 23'd1;
  end

  // 4..6: Horner steps hours, minutes, seconds
  always_comb begin
    st_nxt[4]     = st_r[3];
    st_nxt[4].hrs = 28'(st_r[3].days) * 28'd24 + 28'(st_r[3].c.hour);
  end

  always_comb begin
    st_nxt[5]      = st_r[4];
    st_nxt[5].mins = 34'(st_r[4].hrs) * 34'd60 + 34'(st_r[4].c.minute);
  end

  assign secs = 40'(st_r[5].mins) * 40'd60 + 40'(st_r[5].c.second);
  always_comb begin
    res_nxt = '0;
    if (st_r[5].ok) begin
      res_nxt.valid_res = 1'b1;
      res_nxt.seconds   = secs[38:0];
    end
  end

  assign out_vld = vld_r[LATENCY];
  assign out_res = dly_r[LATENCY];

endmodule
